// File: rtl/pes_header_parser_assert.svh
// ----------------------------------------------------------------------------
// PES header parser assertion macros
// Concurrent checks clocked on clk and masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PES_HEADER_PARSER_ASSERT_SVH
`define PES_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PESHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PESHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/peshp_pkg.sv
// ----------------------------------------------------------------------------
// PES header parser package
// Field widths, byte positions, stream classes and timestamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package peshp_pkg;

  localparam int unsigned IdxW     = 5;
  localparam int unsigned OutDataW = 152;

  // byte counts at which a header is complete; FLAG_BYTE indexes the length byte
  localparam logic [IdxW-1:0] FIXED_BYTES  = 5'd9;
  localparam logic [IdxW-1:0] PTS_END      = 5'd14;
  localparam logic [IdxW-1:0] DTS_END      = 5'd19;
  localparam logic [IdxW-1:0] FLAG_BYTE    = 5'd8;

  localparam logic [7:0] HDR_BITS_FIXED = 8'd72;
  localparam logic [7:0] HDR_BITS_PTS   = 8'd112;
  localparam logic [7:0] HDR_BITS_DTS   = 8'd152;

  localparam logic [1:0] TS_PTS_ONLY = 2'd2;
  localparam logic [1:0] TS_PTS_DTS  = 2'd3;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_VIDEO = 2'd1;
  localparam logic [1:0] CLASS_AUDIO = 2'd2;

  localparam logic [7:0] AUDIO_LO  = 8'hc0;
  localparam logic [7:0] AUDIO_HI  = 8'hdf;
  localparam logic [7:0] AUDIO_EXT = 8'hfd;
  localparam logic [7:0] VIDEO_LO  = 8'he0;
  localparam logic [7:0] VIDEO_HI  = 8'hef;

  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  header_bits;
    logic [1:0]  stream_class;
    logic [1:0]  marker_errors;
    logic [32:0] dts;
    logic [32:0] pts;
    logic [7:0]  header_data_length;
    logic [1:0]  timestamp_flags;
    logic [9:0]  header_flags;
    logic [1:0]  scrambling;
    logic [15:0] packet_length;
    logic [7:0]  stream_code;
    logic [23:0] start_code;
  } result_t;

  // gather the 33 value bits from a 40-bit timestamp field
  function automatic logic [32:0] ts_value(input logic [39:0] f);
    return {f[35:33], f[31:17], f[15:1]};
  endfunction

  // any of the three marker bits clear
  function automatic logic ts_bad(input logic [39:0] f);
    return ~(f[32] & f[16] & f[0]);
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] id);
    logic [1:0] cls;
    if (id >= VIDEO_LO && id <= VIDEO_HI) begin
      cls = CLASS_VIDEO;
    end else if ((id >= AUDIO_LO && id <= AUDIO_HI) || id >= AUDIO_EXT) begin
      cls = CLASS_AUDIO;
    end else begin
      cls = CLASS_OTHER;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pes_header_parser.sv
// ----------------------------------------------------------------------------
// PES header parser
// Byte-serial MPEG-2 PES header field extraction with PTS/DTS assembly.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one header byte per word; in_tuser high marks byte 0 of a packet
//            and restarts the parser from scratch.
//   out_*  : at most one result word per packet, issued when the last byte
//            needed arrives: byte 8 (no timestamps), 13 (PTS) or 18 (PTS and DTS).
//            Further bytes are dropped until the next packet start.
// Throughput: one byte per cycle sustained while out_tready is high. Each byte
//   passes an input register and then a single parse step that updates the
//   header shift registers and, on the final byte, loads the result register.
// Output: the result word is formed from the final byte in the input register and registered.
// Reset: both pipeline stages empty; the parser waits for a packet start,
//   and bytes before the first start yield nothing.
// Stall: while out_tready is low the result holds; one more byte is taken
//   into the empty input register, after which in_tready drops until the
//   result word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pes_header_parser_assert.svh"

module pes_header_parser
  import peshp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // in_tdata: data_byte[7:0]
  input  wire logic [7:0]          in_tdata,
  // in_tuser: packet_start[0]
  input  wire logic                in_tuser,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  // out_tdata from bit 0: start_code[23:0], stream_code[31:24],
  // packet_length[47:32], scrambling[49:48], header_flags[59:50],
  // timestamp_flags[61:60], header_data_length[69:62], pts[102:70],
  // dts[135:103], marker_errors[137:136], stream_class[139:138],
  // header_bits[147:140], zero fill[151:148]
  output      logic [OutDataW-1:0] out_tdata,
  output      logic                out_tvalid,
  input  wire logic                out_tready
);

  // pipeline control
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       out_valid_r;
  result_t    out_data_r;
  logic       advance;

  // parser state
  logic [IdxW-1:0] byte_index_r, byte_index_nxt;
  logic            parse_done_r, parse_done_nxt;
  logic [63:0]     fixed_r, fixed_nxt;
  logic [7:0]      hdr_len_r, hdr_len_nxt;
  logic [39:0]     ts1_r, ts1_nxt;
  logic [39:0]     ts2_r, ts2_nxt;

  logic [IdxW-1:0] idx_base;
  logic            done_base;
  logic [1:0]      tflags;
  logic [IdxW-1:0] need;
  logic [7:0]      hdr_bits;
  logic            emit;
  result_t         result;

  // the result register frees when empty or being taken
  assign advance   = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | advance;

  always_comb begin
    // a packet start behaves as a reset followed by the first byte
    idx_base       = s1_start_r ? '0 : byte_index_r;
    done_base      = s1_start_r ? 1'b0 : parse_done_r;
    fixed_nxt      = s1_start_r ? '0 : fixed_r;
    hdr_len_nxt    = s1_start_r ? '0 : hdr_len_r;
    ts1_nxt        = s1_start_r ? '0 : ts1_r;
    ts2_nxt        = s1_start_r ? '0 : ts2_r;
    byte_index_nxt = idx_base;
    parse_done_nxt = done_base;

    if (!done_base) begin
      if (idx_base < FLAG_BYTE) begin
        fixed_nxt = {fixed_nxt[55:0], s1_byte_r};
      end else if (idx_base == FLAG_BYTE) begin
        hdr_len_nxt = s1_byte_r;
      end else if (idx_base < PTS_END) begin
        ts1_nxt = {ts1_nxt[31:0], s1_byte_r};
      end else begin
        ts2_nxt = {ts2_nxt[31:0], s1_byte_r};
      end
      byte_index_nxt = idx_base + 1'b1;
    end

    // flags are final by the time the count reaches the fixed length
    tflags = fixed_nxt[7:6];
    case (tflags)
      TS_PTS_ONLY: begin
        need     = PTS_END;
        hdr_bits = HDR_BITS_PTS;
      end
      TS_PTS_DTS: begin
        need     = DTS_END;
        hdr_bits = HDR_BITS_DTS;
      end
      default: begin
        need     = FIXED_BYTES;
        hdr_bits = HDR_BITS_FIXED;
      end
    endcase

    emit = ~done_base && (byte_index_nxt >= need);
    if (emit) begin
      parse_done_nxt = 1'b1;
    end

    result                    = '0;
    result.start_code         = fixed_nxt[63:40];
    result.stream_code        = fixed_nxt[39:32];
    result.packet_length      = fixed_nxt[31:16];
    result.scrambling         = fixed_nxt[13:12];
    result.header_flags       = {fixed_nxt[11:8], fixed_nxt[5:0]};
    result.timestamp_flags    = tflags;
    result.header_data_length = hdr_len_nxt;
    result.pts                = tflags[1] ? ts_value(ts1_nxt) : '0;
    result.dts                = (tflags == TS_PTS_DTS) ? ts_value(ts2_nxt) : '0;
    result.marker_errors[0]   = tflags[1] & ts_bad(ts1_nxt);
    result.marker_errors[1]   = (tflags == TS_PTS_DTS) & ts_bad(ts2_nxt);
    result.stream_class       = classify(fixed_nxt[39:32]);
    result.header_bits        = hdr_bits;
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_index_r <= '0;
      parse_done_r <= 1'b1;
      fixed_r      <= '0;
      hdr_len_r    <= '0;
      ts1_r        <= '0;
      ts2_r        <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r & emit;
        if (s1_valid_r) begin
          byte_index_r <= byte_index_nxt;
          parse_done_r <= parse_done_nxt;
          fixed_r      <= fixed_nxt;
          hdr_len_r    <= hdr_len_nxt;
          ts1_r        <= ts1_nxt;
          ts2_r        <= ts2_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (advance && s1_valid_r && emit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a parse in progress never runs past the longest header
  `PESHP_ASSERT_NOW(a_index_range, !parse_done_r, byte_index_r < DTS_END,
    "byte index past end of header")
  // a held byte stays in the input stage while the result stalls
  `PESHP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r,
    "input stage lost a byte during stall")
  // timestamps absent means zero values and no marker errors
  `PESHP_ASSERT_NOW(a_no_ts, out_valid_r && !out_data_r.timestamp_flags[1],
    out_data_r.pts == '0 && out_data_r.dts == '0 && out_data_r.marker_errors == '0,
    "timestamp data without timestamp flags")
  // header length agrees with the flags
  `PESHP_ASSERT_NOW(a_hdr_bits, out_valid_r,
    (out_data_r.timestamp_flags == TS_PTS_DTS && out_data_r.header_bits == HDR_BITS_DTS) ||
    (out_data_r.timestamp_flags == TS_PTS_ONLY && out_data_r.header_bits == HDR_BITS_PTS) ||
    (!out_data_r.timestamp_flags[1] && out_data_r.header_bits == HDR_BITS_FIXED),
    "header bit count inconsistent with flags")

endmodule

`default_nettype wire

// File: bench/pes_header_parser_tb.sv
// ----------------------------------------------------------------------------
// PES header parser testbench
// Streams PES header bytes through the parser with random gaps on the input
// and random stalls on the output. It tracks the parse in a local model and
// compares every result word field by field against the oldest pending
// prediction. Covers bytes before the first start, restarts in mid-packet,
// all PTS_DTS flag values, bad marker bits and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_header_parser_tb;
  import peshp_pkg::*;

  // Cycles with no word moving on either side before the run is abandoned.
  // The slowest legal stretch is the long output hold-off set by HOLD_CYCLES;
  // every other pause is a random idle burst plus the parser's latency.
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 650;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic [7:0]          in_tdata  = '0;
  logic                in_tuser  = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;

  // idling switches and the hold-off request, read by the driver processes
  bit          sender_idle_en   = 1'b1;
  bit          receiver_idle_en = 1'b1;
  int unsigned hold_request     = 0;

  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;

  // predicted result words, oldest first
  result_t pending_headers[$];

  // local copy of the parser state
  logic [4:0]  hp_index = '0;
  logic        hp_done  = 1'b1;
  logic [63:0] hp_fixed = '0;
  logic [7:0]  hp_len   = '0;
  logic [39:0] hp_ts1   = '0;
  logic [39:0] hp_ts2   = '0;

  pes_header_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // 33 value bits of a 40-bit timestamp field: skip the prefix nibble and
  // the three marker bits
  function automatic logic [32:0] timestamp_of(input logic [39:0] f);
    timestamp_of = {f[35:33], f[31:17], f[15:1]};
  endfunction

  function automatic logic marker_broken(input logic [39:0] f);
    marker_broken = !(f[32] && f[16] && f[0]);
  endfunction

  function automatic logic [1:0] stream_class_of(input logic [7:0] id);
    if (id >= VIDEO_LO && id <= VIDEO_HI) begin
      stream_class_of = CLASS_VIDEO;
    end else if ((id >= AUDIO_LO && id <= AUDIO_HI) || id >= AUDIO_EXT) begin
      stream_class_of = CLASS_AUDIO;
    end else begin
      stream_class_of = CLASS_OTHER;
    end
  endfunction

  // Advance the local parse by one accepted byte; queue a result word when
  // the last byte the flags call for has come in.
  task automatic track_header_byte(input logic [7:0] b, input logic s);
    logic [1:0] tflags;
    logic [4:0] need;
    result_t    r;
    if (s) begin
      hp_index = '0;
      hp_done  = 1'b0;
      hp_fixed = '0;
      hp_len   = '0;
      hp_ts1   = '0;
      hp_ts2   = '0;
    end
    if (!hp_done) begin
      if (hp_index < FLAG_BYTE) begin
        hp_fixed = {hp_fixed[55:0], b};
      end else if (hp_index == FLAG_BYTE) begin
        hp_len = b;
      end else if (hp_index < PTS_END) begin
        hp_ts1 = {hp_ts1[31:0], b};
      end else begin
        hp_ts2 = {hp_ts2[31:0], b};
      end
      hp_index = hp_index + 5'd1;
      // flags only mean something once byte 7 is in; need is never below 9
      tflags = hp_fixed[7:6];
      need = (tflags == TS_PTS_DTS)  ? DTS_END :
             (tflags == TS_PTS_ONLY) ? PTS_END : FIXED_BYTES;
      if (hp_index >= FIXED_BYTES && hp_index >= need) begin
        hp_done              = 1'b1;
        r                    = '0;
        r.start_code         = hp_fixed[63:40];
        r.stream_code        = hp_fixed[39:32];
        r.packet_length      = hp_fixed[31:16];
        r.scrambling         = hp_fixed[13:12];
        r.header_flags       = {hp_fixed[11:8], hp_fixed[5:0]};
        r.timestamp_flags    = tflags;
        r.header_data_length = hp_len;
        if (tflags == TS_PTS_ONLY || tflags == TS_PTS_DTS) begin
          r.pts              = timestamp_of(hp_ts1);
          r.marker_errors[0] = marker_broken(hp_ts1);
        end
        if (tflags == TS_PTS_DTS) begin
          r.dts              = timestamp_of(hp_ts2);
          r.marker_errors[1] = marker_broken(hp_ts2);
        end
        r.stream_class = stream_class_of(hp_fixed[39:32]);
        r.header_bits  = (tflags == TS_PTS_DTS)  ? HDR_BITS_DTS :
                         (tflags == TS_PTS_ONLY) ? HDR_BITS_PTS : HDR_BITS_FIXED;
        pending_headers.push_back(r);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one byte and hold it until the parser takes it. Valid stays high
  // after acceptance so back-to-back words need no second assignment.
  task automatic send_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_header_byte(b, s);
    bytes_sent++;
  endtask

  function automatic logic [32:0] rand_timestamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       rand_timestamp = '0;
      1:       rand_timestamp = '1;
      default: rand_timestamp = r[32:0];
    endcase
  endfunction

  // Build a 40-bit timestamp field with good markers, then clear one or all
  // markers when asked. The prefix nibble is left random.
  function automatic logic [39:0] pack_timestamp(input logic [32:0] v, input logic bad);
    logic [3:0]  nib;
    logic [39:0] f;
    nib = 4'($urandom_range(0, 15));
    f = {nib, v[32:30], 1'b1, v[29:15], 1'b1, v[14:0], 1'b1};
    if (bad) begin
      case ($urandom_range(0, 3))
        0:       f[0]  = 1'b0;
        1:       f[16] = 1'b0;
        2:       f[32] = 1'b0;
        default: begin
          f[0]  = 1'b0;
          f[16] = 1'b0;
          f[32] = 1'b0;
        end
      endcase
    end
    pack_timestamp = f;
  endfunction

  // Send one header: as many bytes as its flags need, or only cut bytes if
  // cut is shorter, followed by tail bytes that the parser should drop.
  task automatic send_packet(input logic [23:0] sc, input logic [7:0] id,
                             input logic [15:0] plen, input logic [7:0] b6,
                             input logic [7:0] b7, input logic [7:0] hl,
                             input logic [32:0] pv, input logic [32:0] dv,
                             input logic [1:0] spoil, input int unsigned cut,
                             input int unsigned tail);
    logic [7:0]  hdr [0:18];
    logic [39:0] f1;
    logic [39:0] f2;
    int unsigned len;
    f1     = pack_timestamp(pv, spoil[0]);
    f2     = pack_timestamp(dv, spoil[1]);
    hdr[0] = sc[23:16];
    hdr[1] = sc[15:8];
    hdr[2] = sc[7:0];
    hdr[3] = id;
    hdr[4] = plen[15:8];
    hdr[5] = plen[7:0];
    hdr[6] = b6;
    hdr[7] = b7;
    hdr[8] = hl;
    for (int i = 0; i < 5; i++) begin
      hdr[9 + i]  = f1[39 - 8 * i -: 8];
      hdr[14 + i] = f2[39 - 8 * i -: 8];
    end
    case (b7[7:6])
      TS_PTS_DTS:  len = DTS_END;
      TS_PTS_ONLY: len = PTS_END;
      default:     len = FIXED_BYTES;
    endcase
    if (cut != 0 && cut < len) len = cut;
    for (int i = 0; i < len; i++) begin
      send_byte(hdr[i], i == 0);
    end
    repeat (tail) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Favour the class boundaries so every range edge turns up often.
  function automatic logic [7:0] pick_stream_code();
    logic [7:0] id_bounds [8];
    id_bounds = '{AUDIO_LO - 8'd1, AUDIO_LO, AUDIO_HI, VIDEO_LO, VIDEO_HI,
                  VIDEO_HI + 8'd1, AUDIO_EXT - 8'd1, 8'hff};
    case ($urandom_range(0, 3))
      0: pick_stream_code = 8'($urandom_range(0, 255));
      1: pick_stream_code = VIDEO_LO + 8'($urandom_range(0, 15));
      2: begin
        if ($urandom_range(0, 1) == 0) begin
          pick_stream_code = AUDIO_LO + 8'($urandom_range(0, 31));
        end else begin
          pick_stream_code = AUDIO_EXT + 8'($urandom_range(0, 2));
        end
      end
      default: pick_stream_code = id_bounds[$urandom_range(0, 7)];
    endcase
  endfunction

  // A header with random content; the start code is mostly the real prefix.
  task automatic send_random_header(input logic [1:0] tf, input int unsigned cut,
                                    input int unsigned tail);
    logic [23:0] sc;
    logic [1:0]  spoil;
    sc = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'h000001;
    spoil[0] = ($urandom_range(0, 4) == 0);
    spoil[1] = ($urandom_range(0, 4) == 0);
    send_packet(sc, pick_stream_code(), 16'($urandom), 8'($urandom_range(0, 255)),
                {tf, 6'($urandom_range(0, 63))}, 8'($urandom_range(0, 255)),
                rand_timestamp(), rand_timestamp(), spoil, cut, tail);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Ready in random stall bursts; a hold-off request overrides everything
  // and is counted out here, not in the test that asks for it.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!receiver_idle_en) begin
        out_tready <= 1'b1;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_headers.size() == 0) begin
        $error("result word with nothing pending: stream_code %0h", got.stream_code);
        error_count++;
      end else begin
        want = pending_headers.pop_front();
        check_field("start_code", want.start_code, got.start_code);
        check_field("stream_code", want.stream_code, got.stream_code);
        check_field("packet_length", want.packet_length, got.packet_length);
        check_field("scrambling", want.scrambling, got.scrambling);
        check_field("header_flags", want.header_flags, got.header_flags);
        check_field("timestamp_flags", want.timestamp_flags, got.timestamp_flags);
        check_field("header_data_length", want.header_data_length,
                    got.header_data_length);
        check_field("pts", want.pts, got.pts);
        check_field("dts", want.dts, got.dts);
        check_field("marker_errors", want.marker_errors, got.marker_errors);
        check_field("stream_class", want.stream_class, got.stream_class);
        check_field("header_bits", want.header_bits, got.header_bits);
      end
    end
  end

  // Abandon the run when no word has moved on either side for too long.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Bytes after reset but before any packet start must be dropped.
  task automatic test_bytes_before_start();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Abandon a header after four bytes and start again; the new header has every
  // fixed field at its maximum but timestamp flags 01, and a byte to drop follows.
  task automatic test_restart();
    send_random_header(TS_PTS_DTS, 4, 0);
    send_packet(24'hffffff, 8'hff, 16'hffff, 8'hff, 8'h7f, 8'hff,
                '0, '0, 2'b00, 0, 1);
  endtask

  // PTS and DTS at opposite extremes, with a broken PTS marker.
  task automatic test_timestamps();
    send_packet(24'h000000, 8'h00, 16'h0000, 8'h00, {TS_PTS_DTS, 6'h00}, 8'h00,
                33'h0, 33'h1ffffffff, 2'b01, 0, 0);
  endtask

  // Mostly well-formed headers with random content; the rest is noise and
  // headers cut short by the next start.
  task automatic test_random_headers();
    int unsigned stop_at;
    int unsigned n;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        1: send_random_header(2'($urandom_range(0, 3)), $urandom_range(1, 18), 0);
        default: send_random_header(2'($urandom_range(0, 3)), 0, $urandom_range(0, 2));
      endcase
    end
  endtask

  // Hold the output off for a long stretch while headers keep coming, so the
  // result register fills, one more byte lands and the input stalls.
  task automatic test_input_stall();
    sender_idle_en = 1'b0;
    hold_request   = HOLD_CYCLES;
    repeat (4) send_random_header(TS_PTS_DTS, 0, 0);
    sender_idle_en = 1'b1;
  endtask

  // Full rate on both sides to close the run.
  task automatic test_back_to_back();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (12) send_random_header(2'($urandom_range(0, 3)), 0, $urandom_range(0, 1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_bytes_before_start();
    test_restart();
    test_timestamps();
    test_random_headers();
    test_input_stall();
    test_back_to_back();

    // drop valid, wait out the pending results and the pipeline
    in_tvalid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
